// ----- design/i2c_master_message_sequencer_macros.svh -----
// Assertion macros used by the I2C message sequencer checker.
`ifndef I2C_MASTER_MESSAGE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_MESSAGE_SEQUENCER_MACROS_SVH

// Same-cycle implication under an active-low reset.
`define I2CMS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication under an active-low reset.
`define I2CMS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/i2cms_pkg.sv -----
// Types, codes and constants of the I2C master message sequencer.
package i2cms_pkg;

    localparam int MAX_MESSAGES_DEF = 8;
    localparam int MAX_BYTES_DEF    = 256;

    typedef enum logic [1:0] {
        FUNC_LOAD_DESC = 2'd0,
        FUNC_LOAD_BYTE = 2'd1,
        FUNC_START     = 2'd2,
        FUNC_IRQ       = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_START = 3'd1,
        PH_READ  = 3'd2,
        PH_WRITE = 3'd3,
        PH_STOP  = 3'd4
    } t_phase;

    localparam logic [7:0] STATUS_START_READ   = 8'hb0;
    localparam logic [7:0] STATUS_START_WRITE  = 8'hf0;
    localparam logic [7:0] STATUS_STOP_READ    = 8'hd0;
    localparam logic [7:0] STATUS_STOP_WRITE   = 8'h90;
    localparam logic [7:0] CONTROL_RESUME_ACK  = 8'haf;
    localparam logic [7:0] CONTROL_RESUME_NACK = 8'h2f;

    typedef struct packed {
        t_func       func;
        logic [2:0]  msg_index;
        logic [6:0]  slave_addr;
        logic        is_read;
        logic [8:0]  msg_len;
        logic [7:0]  byte_index;
        logic [7:0]  data_byte;
        logic [3:0]  msg_count;
        logic        nack;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic        data_write;
        logic [7:0]  data_value;
        logic        status_write;
        logic [7:0]  status_value;
        logic        control_write;
        logic [7:0]  control_value;
        logic        rx_valid;
        logic [2:0]  rx_message;
        logic [7:0]  rx_index;
        logic [7:0]  rx_data;
        logic        done_res;
        logic        error;
    } t_out_item;

endpackage

// ----- design/i2cms_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module i2cms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/i2c_master_message_sequencer.sv -----
// Top level of the I2C master message sequencer.
//
//   Channel   Valid         Stall         Payload
//   input     i_in_valid    o_in_stall    i_in_item  (t_in_item)
//   output    o_out_valid   i_out_stall   o_out_item (t_out_item)
//
// One item is taken per cycle while the input is not stalled; its result appears in the
// output register on the next cycle. The descriptor and transmit memories are read every
// cycle at the address of the next state, so the entries an interrupt needs are ready when
// it arrives; writes that hit the same entry are forwarded. Reset clears the sequencing
// state and the output valid flag; the memory contents are undefined until written. The
// input stalls only while a result waits and the output is stalled.
module i2c_master_message_sequencer #(
    parameter int MAX_MESSAGES = i2cms_pkg::MAX_MESSAGES_DEF,
    parameter int MAX_BYTES    = i2cms_pkg::MAX_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  i2cms_pkg::t_in_item  i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output i2cms_pkg::t_out_item o_out_item,
    input  logic                 i_out_stall
);

    import i2cms_pkg::*;

    localparam int MSG_AW  = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
    localparam int BYTE_AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int BP_W    = $clog2(MAX_BYTES + 1);
    localparam int MT_W    = $clog2(MAX_MESSAGES + 1);
    localparam int DESC_W  = 8 + BP_W;
    localparam int TX_AW   = MSG_AW + BYTE_AW;

    t_phase            r_phase, n_phase;
    logic [MSG_AW-1:0] r_cm, n_cm;
    logic [BP_W-1:0]   r_bp, n_bp;
    logic [MT_W-1:0]   r_total, n_total;

    logic              r_out_valid;
    t_out_item         r_out_item, n_out;

    logic              w_accept;
    logic              w_idx_ok;
    logic              w_desc_we, w_tx_we;
    logic [DESC_W-1:0] w_desc_wdata;
    logic [MSG_AW-1:0] w_desc_waddr;
    logic [TX_AW-1:0]  w_tx_waddr;
    logic [BP_W-1:0]   w_len_sat;
    logic [MT_W-1:0]   w_cnt_sat;

    logic [MSG_AW-1:0] a_cm, a_cm_next;
    logic [TX_AW-1:0]  a_tx;

    logic [DESC_W-1:0] w_ram_a, w_ram_b;
    logic [7:0]        w_ram_tx;
    logic              r_fwd_a, r_fwd_b, r_fwd_tx;
    logic [DESC_W-1:0] r_fwd_desc;
    logic [7:0]        r_fwd_tx_data;
    logic [DESC_W-1:0] r_desc0;

    logic [DESC_W-1:0] w_desc_cur, w_desc_nxt;
    logic [7:0]        w_tx_byte;
    logic              w_last;

    logic              c_read_next, c_write_next, c_msg_end, c_stop, c_stop_err;
    logic [BP_W-1:0]   c_bp;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;

    assign w_idx_ok = {29'd0, i_in_item.msg_index} < 32'(MAX_MESSAGES);
    assign w_len_sat = ({23'd0, i_in_item.msg_len} > 32'(MAX_BYTES)) ?
                       BP_W'(MAX_BYTES) : BP_W'(i_in_item.msg_len);
    assign w_cnt_sat = ({28'd0, i_in_item.msg_count} > 32'(MAX_MESSAGES)) ?
                       MT_W'(MAX_MESSAGES) : MT_W'(i_in_item.msg_count);

    assign w_desc_we    = w_accept && (i_in_item.func == FUNC_LOAD_DESC) && w_idx_ok;
    assign w_desc_waddr = MSG_AW'(i_in_item.msg_index);
    assign w_desc_wdata = {w_len_sat, i_in_item.is_read, i_in_item.slave_addr};
    assign w_tx_we      = w_accept && (i_in_item.func == FUNC_LOAD_BYTE) && w_idx_ok
                          && ({24'd0, i_in_item.byte_index} < 32'(MAX_BYTES));
    assign w_tx_waddr   = {MSG_AW'(i_in_item.msg_index), BYTE_AW'(i_in_item.byte_index)};

    assign a_cm      = i_rst_n ? n_cm : '0;
    assign a_cm_next = a_cm + MSG_AW'(1);
    assign a_tx      = i_rst_n ? {n_cm, n_bp[BYTE_AW-1:0]} : '0;

    i2cms_ram #(.WIDTH(DESC_W), .DEPTH(1 << MSG_AW)) u_desc_cur (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (w_desc_waddr),
        .i_wdata (w_desc_wdata),
        .i_raddr (a_cm),
        .o_rdata (w_ram_a)
    );

    i2cms_ram #(.WIDTH(DESC_W), .DEPTH(1 << MSG_AW)) u_desc_nxt (
        .i_clk   (i_clk),
        .i_we    (w_desc_we),
        .i_waddr (w_desc_waddr),
        .i_wdata (w_desc_wdata),
        .i_raddr (a_cm_next),
        .o_rdata (w_ram_b)
    );

    i2cms_ram #(.WIDTH(8), .DEPTH(1 << TX_AW)) u_tx_buf (
        .i_clk   (i_clk),
        .i_we    (w_tx_we),
        .i_waddr (w_tx_waddr),
        .i_wdata (i_in_item.data_byte),
        .i_raddr (a_tx),
        .o_rdata (w_ram_tx)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_a  <= 1'b0;
            r_fwd_b  <= 1'b0;
            r_fwd_tx <= 1'b0;
        end else begin
            r_fwd_a  <= w_desc_we && (w_desc_waddr == a_cm);
            r_fwd_b  <= w_desc_we && (w_desc_waddr == a_cm_next);
            r_fwd_tx <= w_tx_we && (w_tx_waddr == a_tx);
        end
        r_fwd_desc    <= w_desc_wdata;
        r_fwd_tx_data <= i_in_item.data_byte;
        if (w_desc_we && (w_desc_waddr == '0)) begin
            r_desc0 <= w_desc_wdata;
        end
    end

    assign w_desc_cur = r_fwd_a ? r_fwd_desc : w_ram_a;
    assign w_desc_nxt = r_fwd_b ? r_fwd_desc : w_ram_b;
    assign w_tx_byte  = r_fwd_tx ? r_fwd_tx_data : w_ram_tx;
    assign w_last     = (32'(r_cm) + 32'd1) == 32'(r_total);

    always_comb begin
        n_phase      = r_phase;
        n_cm         = r_cm;
        n_bp         = r_bp;
        n_total      = r_total;
        n_out        = '0;
        c_read_next  = 1'b0;
        c_write_next = 1'b0;
        c_msg_end    = 1'b0;
        c_stop       = 1'b0;
        c_stop_err   = 1'b0;
        c_bp         = r_bp;

        if (w_accept) begin
            unique case (i_in_item.func)
                FUNC_LOAD_DESC, FUNC_LOAD_BYTE: begin
                end
                FUNC_START: begin
                    if (i_in_item.msg_count != 4'd0) begin
                        n_total              = w_cnt_sat;
                        n_cm                 = '0;
                        n_bp                 = '0;
                        n_phase              = PH_START;
                        n_out.data_write     = 1'b1;
                        n_out.data_value     = {r_desc0[6:0], 1'b0};
                        n_out.status_write   = 1'b1;
                        n_out.status_value   = r_desc0[7] ? STATUS_START_READ
                                                          : STATUS_START_WRITE;
                    end
                end
                FUNC_IRQ: begin
                    unique case (r_phase)
                        PH_START: begin
                            if (i_in_item.nack) begin
                                c_stop     = 1'b1;
                                c_stop_err = 1'b1;
                            end else if (w_last && (r_bp >= w_desc_cur[DESC_W-1:8])) begin
                                c_stop = 1'b1;
                            end else if (w_desc_cur[7]) begin
                                n_phase     = PH_READ;
                                c_read_next = 1'b1;
                            end else begin
                                n_phase      = PH_WRITE;
                                c_write_next = 1'b1;
                            end
                        end
                        PH_WRITE: c_write_next = 1'b1;
                        PH_READ: begin
                            n_out.rx_valid   = 1'b1;
                            n_out.rx_message = 3'(r_cm);
                            n_out.rx_index   = 8'(r_bp);
                            n_out.rx_data    = i_in_item.rx_byte;
                            c_bp             = r_bp + BP_W'(1);
                            n_bp             = c_bp;
                            c_read_next      = 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        if (c_read_next) begin
            if (c_bp < w_desc_cur[DESC_W-1:8]) begin
                n_out.control_write = 1'b1;
                n_out.control_value = ((c_bp + BP_W'(1)) == w_desc_cur[DESC_W-1:8]) ?
                                      CONTROL_RESUME_NACK : CONTROL_RESUME_ACK;
            end else begin
                c_msg_end = 1'b1;
            end
        end

        if (c_write_next) begin
            if (c_bp < w_desc_cur[DESC_W-1:8]) begin
                n_out.data_write    = 1'b1;
                n_out.data_value    = w_tx_byte;
                n_bp                = c_bp + BP_W'(1);
                n_out.control_write = 1'b1;
                n_out.control_value = CONTROL_RESUME_ACK;
            end else begin
                c_msg_end = 1'b1;
            end
        end

        if (c_msg_end) begin
            if (!w_last) begin
                n_cm               = r_cm + MSG_AW'(1);
                n_bp               = '0;
                n_phase            = PH_START;
                n_out.data_write   = 1'b1;
                n_out.data_value   = {w_desc_nxt[6:0], 1'b0};
                n_out.status_write = 1'b1;
                n_out.status_value = w_desc_nxt[7] ? STATUS_START_READ : STATUS_START_WRITE;
            end else begin
                c_stop = 1'b1;
            end
        end

        if (c_stop) begin
            n_phase             = PH_STOP;
            n_out.status_write  = 1'b1;
            n_out.status_value  = w_desc_cur[7] ? STATUS_STOP_READ : STATUS_STOP_WRITE;
            n_out.control_write = 1'b1;
            n_out.control_value = CONTROL_RESUME_ACK;
            n_out.done_res      = 1'b1;
            n_out.error         = c_stop_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_cm        <= '0;
            r_bp        <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_cm    <= n_cm;
            r_bp    <= n_bp;
            r_total <= n_total;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_out_item <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- design/i2cms_checker.sv -----
// Port-level checker for the I2C master message sequencer and its bind.
`include "i2c_master_message_sequencer_macros.svh"

module i2cms_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input i2cms_pkg::t_in_item  i_in_item,
    input logic                 o_in_stall,
    input logic                 o_out_valid,
    input i2cms_pkg::t_out_item o_out_item,
    input logic                 i_out_stall
);

    import i2cms_pkg::*;

    `I2CMS_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item), "Stalled result changed.")

    `I2CMS_ASSERT_IMP(a_stall_cause, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall, "Input stalled without a waiting result.")

    `I2CMS_ASSERT_NXT(a_one_result, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_out_valid, "Accepted item gave no result.")

    `I2CMS_ASSERT_NXT(a_load_quiet, i_clk, i_rst_n, i_in_valid && !o_in_stall && (i_in_item.func == FUNC_LOAD_DESC || i_in_item.func == FUNC_LOAD_BYTE), o_out_item == '0, "Load item gave a nonzero result.")

    `I2CMS_ASSERT_IMP(a_stop_form, i_clk, i_rst_n, o_out_valid && o_out_item.done_res, o_out_item.status_write && o_out_item.control_write, "Done without stop writes.")

endmodule

bind i2c_master_message_sequencer i2cms_checker u_checker (.*);

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// Self-checking testbench that drives load, start and byte-done items into the I2C message sequencer and predicts every controller action.
module tb_top;
    import i2cms_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int ITEM_GOAL      = 550;
    localparam int QUIET_TAIL     = 60;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;
    logic      out_stall = 1'b0;

    // Predicted sequencer state.
    t_phase      seq_phase = PH_IDLE;
    int unsigned cur_msg   = 0;
    int unsigned byte_ptr  = 0;
    int unsigned msg_total = 0;
    logic [6:0]  desc_addr [MAX_MESSAGES_DEF];
    logic        desc_read [MAX_MESSAGES_DEF];
    int unsigned desc_len  [MAX_MESSAGES_DEF];
    logic [7:0]  tx_bytes  [MAX_MESSAGES_DEF][MAX_BYTES_DEF];
    bit          byte_written [MAX_MESSAGES_DEF][MAX_BYTES_DEF];
    t_out_item   next_action;

    t_out_item   expected_actions [$];
    int unsigned items_sent    = 0;
    int unsigned mismatches    = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned stall_left    = 0;
    bit          sender_idle   = 1'b1;
    bit          receiver_idle = 1'b1;

    i2c_master_message_sequencer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void open_message();
        seq_phase = PH_START;
        next_action.data_write   = 1'b1;
        next_action.data_value   = {desc_addr[cur_msg], 1'b0};
        next_action.status_write = 1'b1;
        next_action.status_value = desc_read[cur_msg] ? STATUS_START_READ : STATUS_START_WRITE;
    endfunction

    function automatic void end_transfer(input logic err);
        seq_phase = PH_STOP;
        next_action.status_write  = 1'b1;
        next_action.status_value  = desc_read[cur_msg] ? STATUS_STOP_READ : STATUS_STOP_WRITE;
        next_action.control_write = 1'b1;
        next_action.control_value = CONTROL_RESUME_ACK;
        next_action.done_res      = 1'b1;
        next_action.error         = err;
    endfunction

    function automatic void advance_message();
        if (cur_msg + 1 != msg_total) begin
            cur_msg++;
            byte_ptr = 0;
            open_message();
        end else begin
            end_transfer(1'b0);
        end
    endfunction

    function automatic void read_step();
        if (byte_ptr < desc_len[cur_msg]) begin
            next_action.control_write = 1'b1;
            next_action.control_value = (byte_ptr + 1 == desc_len[cur_msg]) ?
                CONTROL_RESUME_NACK : CONTROL_RESUME_ACK;
        end else begin
            advance_message();
        end
    endfunction

    function automatic void write_step();
        if (byte_ptr < desc_len[cur_msg]) begin
            next_action.data_write    = 1'b1;
            next_action.data_value    = tx_bytes[cur_msg][byte_ptr];
            byte_ptr++;
            next_action.control_write = 1'b1;
            next_action.control_value = CONTROL_RESUME_ACK;
        end else begin
            advance_message();
        end
    endfunction

    function automatic t_out_item sequence_step(input t_in_item it);
        int unsigned count;
        int unsigned len;
        next_action = '0;
        case (it.func)
            FUNC_LOAD_DESC: begin
                len = 32'(it.msg_len);
                if (len > MAX_BYTES_DEF) len = MAX_BYTES_DEF;
                desc_addr[it.msg_index] = it.slave_addr;
                desc_read[it.msg_index] = it.is_read;
                desc_len[it.msg_index]  = len;
            end
            FUNC_LOAD_BYTE: begin
                tx_bytes[it.msg_index][it.byte_index] = it.data_byte;
            end
            FUNC_START: begin
                count = 32'(it.msg_count);
                if (count != 0) begin
                    if (count > MAX_MESSAGES_DEF) count = MAX_MESSAGES_DEF;
                    msg_total = count;
                    cur_msg   = 0;
                    byte_ptr  = 0;
                    open_message();
                end
            end
            default: begin
                case (seq_phase)
                    PH_START: begin
                        if (it.nack) begin
                            end_transfer(1'b1);
                        end else if (cur_msg + 1 == msg_total && byte_ptr >= desc_len[cur_msg]) begin
                            end_transfer(1'b0);
                        end else if (desc_read[cur_msg]) begin
                            seq_phase = PH_READ;
                            read_step();
                        end else begin
                            seq_phase = PH_WRITE;
                            write_step();
                        end
                    end
                    PH_WRITE: write_step();
                    PH_READ: begin
                        next_action.rx_valid   = 1'b1;
                        next_action.rx_message = cur_msg[2:0];
                        next_action.rx_index   = byte_ptr[7:0];
                        next_action.rx_data    = it.rx_byte;
                        byte_ptr++;
                        read_step();
                    end
                    default: ;
                endcase
            end
        endcase
        return next_action;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40) $display("%0t ns: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want);
        if (got != want) report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
    endtask

    always @(posedge clk) begin : check_results
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_actions.size() == 0) begin
                report_mismatch("result with no item pending");
            end else begin
                want = expected_actions.pop_front();
                check_field("data_write", 32'(out_item.data_write), 32'(want.data_write));
                check_field("data_value", 32'(out_item.data_value), 32'(want.data_value));
                check_field("status_write", 32'(out_item.status_write), 32'(want.status_write));
                check_field("status_value", 32'(out_item.status_value), 32'(want.status_value));
                check_field("control_write", 32'(out_item.control_write),
                            32'(want.control_write));
                check_field("control_value", 32'(out_item.control_value),
                            32'(want.control_value));
                check_field("rx_valid", 32'(out_item.rx_valid), 32'(want.rx_valid));
                check_field("rx_message", 32'(out_item.rx_message), 32'(want.rx_message));
                check_field("rx_index", 32'(out_item.rx_index), 32'(want.rx_index));
                check_field("rx_data", 32'(out_item.rx_data), 32'(want.rx_data));
                check_field("done_res", 32'(out_item.done_res), 32'(want.done_res));
                check_field("error", 32'(out_item.error), 32'(want.error));
            end
        end
    end

    always @(posedge clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (receiver_idle && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            out_stall  <= 1'b1;
        end else begin
            out_stall  <= 1'b0;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("[i2c_master_message_sequencer] ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic t_in_item random_item();
        logic [63:0] bits;
        bits = {$urandom, $urandom};
        return bits[$bits(t_in_item)-1:0];
    endfunction

    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (items_sent + QUIET_TAIL >= ITEM_GOAL) begin
            sender_idle   = 1'b0;
            receiver_idle = 1'b0;
        end
        if (sender_idle && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 17);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        expected_actions.push_back(sequence_step(it));
        items_sent++;
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_actions.size() != 0) @(posedge clk);
    endtask

    task automatic load_byte(input int unsigned slot, input int unsigned idx, input logic [7:0] value);
        t_in_item it;
        it = random_item();
        it.func       = FUNC_LOAD_BYTE;
        it.msg_index  = slot[2:0];
        it.byte_index = idx[7:0];
        it.data_byte  = value;
        byte_written[slot][idx] = 1'b1;
        send_item(it);
    endtask

    // A write descriptor is loaded only once all of its bytes are in the buffer.
    task automatic load_descriptor(input int unsigned slot, input int unsigned addr,
                                   input logic rd, input int unsigned len);
        t_in_item    it;
        int unsigned b;
        if (!rd) begin
            for (b = 0; b < len && b < MAX_BYTES_DEF; b++) begin
                if (!byte_written[slot][b]) load_byte(slot, b, 8'($urandom_range(0, 255)));
            end
        end
        it = random_item();
        it.func       = FUNC_LOAD_DESC;
        it.msg_index  = slot[2:0];
        it.slave_addr = addr[6:0];
        it.is_read    = rd;
        it.msg_len    = len[8:0];
        send_item(it);
    endtask

    task automatic load_random_descriptor(input int unsigned slot);
        int unsigned pick;
        int unsigned len;
        logic        rd;
        rd   = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 19);
        if (pick < 14) len = $urandom_range(0, 4);
        else if (pick < 18) len = $urandom_range(5, 12);
        else len = rd ? $urandom_range(13, 40) : $urandom_range(13, 24);
        load_descriptor(slot, $urandom_range(0, 127), rd, len);
    endtask

    task automatic start_transfer(input int unsigned count);
        t_in_item it;
        it = random_item();
        it.func      = FUNC_START;
        it.msg_count = count[3:0];
        send_item(it);
    endtask

    task automatic byte_done(input logic nack, input logic [7:0] rx);
        t_in_item it;
        it = random_item();
        it.func    = FUNC_IRQ;
        it.nack    = nack;
        it.rx_byte = rx;
        send_item(it);
    endtask

    task automatic test_directed();
        int unsigned slot;
        load_byte(0, 0, 8'h00);
        load_byte(0, 1, 8'hff);
        load_byte(7, 255, 8'h5a);
        load_descriptor(0, 127, 1'b0, 2);
        load_descriptor(1, 0, 1'b1, 1);
        load_descriptor(2, 7'h55, 1'b0, 0);
        load_descriptor(3, 7'h2a, 1'b1, 511);
        for (slot = 4; slot < MAX_MESSAGES_DEF; slot++) begin
            load_descriptor(slot, $urandom_range(0, 127), 1'b1, 1);
        end
        start_transfer(2);
        byte_done(1'b0, 8'h00);
        byte_done(1'b0, 8'h00);
        byte_done(1'b0, 8'h00);
        byte_done(1'b0, 8'h00);
        byte_done(1'b0, 8'hff);
        byte_done(1'b1, 8'h00);
        start_transfer(0);
        start_transfer(15);
        byte_done(1'b1, 8'h00);
        start_transfer(3);
        byte_done(1'b0, 8'h00);
        start_transfer(1);
        byte_done(1'b0, 8'h00);
    endtask

    // A read whose length saturates at the buffer size, run to its stop.
    task automatic test_long_read();
        load_descriptor(0, $urandom_range(0, 127), 1'b1, 511);
        start_transfer(1);
        while (seq_phase != PH_STOP) byte_done(1'b0, 8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_transfers();
        int unsigned n;
        int unsigned slot;
        int unsigned count;
        int unsigned steps;
        logic        nack_bit;
        while (items_sent < ITEM_GOAL) begin
            if (items_sent + QUIET_TAIL >= ITEM_GOAL) begin
                sender_idle   = 1'b0;
                receiver_idle = 1'b0;
            end else begin
                sender_idle   = $urandom_range(0, 3) != 0;
                receiver_idle = $urandom_range(0, 3) != 0;
            end
            n = $urandom_range(1, $urandom_range(1, MAX_MESSAGES_DEF));
            for (slot = 0; slot < n; slot++) begin
                if ($urandom_range(0, 2) != 0) load_random_descriptor(slot);
            end
            if ($urandom_range(0, 5) == 0) begin
                load_byte($urandom_range(0, 7), $urandom_range(0, 255), 8'($urandom_range(0, 255)));
            end
            count = n;
            if (n == MAX_MESSAGES_DEF && $urandom_range(0, 1) == 1) count = $urandom_range(9, 15);
            start_transfer(count);
            steps = 0;
            while (seq_phase != PH_STOP && steps < 80) begin
                case ($urandom_range(0, 29))
                    0: start_transfer($urandom_range(0, 15));
                    1: load_random_descriptor($urandom_range(0, 7));
                    2: load_byte($urandom_range(0, 7), $urandom_range(0, 255),
                                 8'($urandom_range(0, 255)));
                    default: begin
                        if (seq_phase == PH_START) nack_bit = $urandom_range(0, 11) == 0;
                        else nack_bit = 1'($urandom_range(0, 1));
                        byte_done(nack_bit, 8'($urandom_range(0, 255)));
                    end
                endcase
                steps++;
            end
            if ($urandom_range(0, 3) == 0) begin
                byte_done(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        wait_for_results();
        test_long_read();
        wait_for_results();
        test_random_transfers();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("[i2c_master_message_sequencer] OK");
        end else begin
            $display("[i2c_master_message_sequencer] ERROR");
        end
        $finish;
    end

endmodule
